/* hdl/tfcr_pkg.sv */
// Package for the touch frame to contact report block.
// Holds constants, codes, word types and the position clamp helper.
// No dependencies; every other file in hdl/ depends on it.
`default_nettype none

package tfcr_pkg;

  // Frame layout and limits
  localparam int MAX_CONTACTS        = 5;
  localparam int FINGER_RECORD_BYTES = 30;
  localparam int HEADER_BYTES        = 46;
  localparam int FIRST_FRAME_CAP     = 80;
  localparam int TICKS_PER_UNIT      = 1000;
  localparam int SCAN_W              = 16;
  localparam int SCAN_MAX            = 16'hFFFF;
  localparam int CNT_W               = 3;
  localparam int NEED_W              = 17;

  // Scan time divider: gaps at or above SCAN_LIMIT saturate, the rest are
  // divided by a reciprocal multiply that is exact over DIV_IN_W bits.
  localparam longint SCAN_LIMIT = longint'(SCAN_MAX + 1) * TICKS_PER_UNIT;
  localparam int     DIV_IN_W   = $clog2(SCAN_LIMIT);
  localparam int     DIV_SHIFT  = DIV_IN_W + $clog2(TICKS_PER_UNIT);
  localparam longint DIV_RECIP  =
    ((longint'(1) << DIV_SHIFT) + TICKS_PER_UNIT - 1) / TICKS_PER_UNIT;
  localparam int     RECIP_W    = DIV_SHIFT - $clog2(TICKS_PER_UNIT) + 1;
  localparam int     PROD_W     = DIV_IN_W + RECIP_W;

  // Result queue
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration reset values
  localparam logic [15:0] PALM_THR_RST = 16'd3500;
  localparam logic [15:0] IDLE_GAP_RST = 16'd5000;

  typedef enum logic { OP_HEADER = 1'b0, OP_FINGER = 1'b1 } op_t;
  typedef enum logic { KIND_CONTACT = 1'b0, KIND_SUMMARY = 1'b1 } kind_t;
  typedef enum logic { STATUS_OK = 1'b0, STATUS_LEN_ERR = 1'b1 } status_t;
  typedef enum logic [1:0] { SCAN_ZERO, SCAN_OWN, SCAN_FRAME } scan_src_t;

  typedef enum logic [2:0] {
    CFG_PALM_MAJOR  = 3'd0,
    CFG_PALM_MINOR  = 3'd1,
    CFG_X_ORIGIN    = 3'd2,
    CFG_Y_TOP       = 3'd3,
    CFG_X_SPAN      = 3'd4,
    CFG_Y_SPAN      = 3'd5,
    CFG_REPORT_EN   = 3'd6,
    CFG_IDLE_GAP    = 3'd7
  } cfg_index_t;

  typedef struct packed {
    op_t                op;
    logic [63:0]        timestamp;
    logic [15:0]        packet_length;
    logic [7:0]         finger_count;
    logic               click;
    logic signed [15:0] finger_x;
    logic signed [15:0] finger_y;
    logic signed [15:0] finger_pressure;
    logic [15:0]        touch_major;
    logic [15:0]        touch_minor;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  contact_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        tip_switch;
    logic [2:0]  contact_count;
    logic        button_clicked;
    logic [15:0] scan_time;
    status_t     status;
    logic        last;
  } out_word_t;

  // What one input word leaves behind: an optional contact, an optional summary
  typedef struct packed {
    logic             has_contact;
    logic [CNT_W-1:0] contact_id;
    logic [15:0]      pos_x;
    logic [15:0]      pos_y;
    logic             tip;
    logic             has_summary;
    logic [CNT_W-1:0] sum_count;
    logic             sum_click;
    status_t          sum_status;
    scan_src_t        scan_src;
  } entry_t;

  // Queue entry with the summary scan time resolved
  typedef struct packed {
    entry_t            e;
    logic [SCAN_W-1:0] scan;
  } q_entry_t;

  // Clamp a normalized coordinate to [0, span]
  function automatic logic [15:0] clamp_span(logic signed [16:0] n, logic [15:0] span);
    logic [15:0] res;
    if (n <= 17'sd0) begin
      res = '0;
    end else if (n[15:0] >= span) begin
      res = span;
    end else begin
      res = n[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/tfcr_in_if.sv */
// Input channel of the touch frame block: header and finger words.
// Depends on tfcr_pkg for the word type.
`default_nettype none

interface tfcr_in_if;
  logic               valid;
  logic               ready;
  tfcr_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/tfcr_out_if.sv */
// Result channel of the touch frame block: contact and summary words.
// Depends on tfcr_pkg for the word type.
`default_nettype none

interface tfcr_out_if;
  logic                valid;
  logic                ready;
  tfcr_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/tfcr_cfg_if.sv */
// Configuration write channel of the touch frame block.
// Depends on tfcr_pkg for the register index type.
`default_nettype none

interface tfcr_cfg_if;
  logic                  valid;
  logic                  ready;
  tfcr_pkg::cfg_index_t  index;
  logic [15:0]           wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

/* hdl/touch_frame_to_contact_report_top.sv */
// Touch frame to contact report converter, top level.
// Depends on tfcr_pkg and the tfcr_in_if, tfcr_out_if, tfcr_cfg_if interfaces.
//
// Usage:
//   in_ch takes one word per cycle while in_ch.ready is high: a frame header (op 0) or a finger record
//   (op 1). A header checks the packet length, computes the scan time and
//   opens a frame; each non-palm finger yields a contact word, and the last
//   expected finger adds the summary word (last = 1). Disabled mode, length
//   errors and zero-finger headers give their summary at once.
//   out_ch delivers one result word per cycle while the receiver is ready; a word that yields a contact
//   and a summary delivers them on two consecutive handshakes.
//   cfg_ch writes one register per handshake and is always ready; write only
//   while no words are in flight.
// Timing:
//   Three register stages (input, reciprocal multiply for the divide by 1000,
//   scan time resolve) then an 8-entry result queue that feeds out_ch.
//   Sustained rate is one input word per cycle, bounded by the output port
//   at one result word per cycle. in_ch.ready drops when the queue plus the
//   words in flight would fill it, so a stalled receiver backs up into the
//   input without loss.
// Reset: synchronous, clears the frame and timing state, empties the queue
//   and loads the default register values.
`default_nettype none

module touch_frame_to_contact_report_top (
  input  logic       clk,
  input  logic       rst_n,
  tfcr_in_if.sink    in_ch,
  tfcr_out_if.source out_ch,
  tfcr_cfg_if.sink   cfg_ch
);
  import tfcr_pkg::*;

  // Configuration registers
  logic [15:0] palm_major_r, palm_minor_r, x_origin_r, y_top_r;
  logic [15:0] x_span_r, y_span_r, idle_gap_r;
  logic        report_en_r;

  // Frame and timing state
  logic [63:0]       last_time_r, last_time_nxt;
  logic [CNT_W-1:0]  prev_total_r, prev_total_nxt;
  logic              frame_open_r, frame_open_nxt;
  logic [CNT_W-1:0]  expected_r, expected_nxt;
  logic [CNT_W-1:0]  finger_idx_r, finger_idx_nxt;
  logic [CNT_W-1:0]  reported_r, reported_nxt;
  logic              frame_click_r, frame_click_nxt;
  logic [SCAN_W-1:0] frame_scan_r;

  // Pipeline stages
  logic              s1_valid_r, s2_valid_r, s3_valid_r;
  in_word_t          s1_item_r;
  entry_t            s1_entry, s2_entry_r, s3_entry_r;
  logic              s1_hdr_open, s2_hdr_open_r, s3_hdr_open_r;
  logic              s1_cap_ok, s2_cap_ok_r, s3_cap_ok_r;
  logic              s1_sat, s2_sat_r, s3_sat_r;
  logic [63:0]       s1_diff;
  logic [DIV_IN_W-1:0] s2_diff_r;
  logic [PROD_W-1:0] s2_prod;
  logic [SCAN_W-1:0] s3_quot_r;

  // Result queue
  q_entry_t          q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r;
  logic              phase_r;
  logic              push, pop_word, pop_entry;
  q_entry_t          head;
  q_entry_t          s3_q;
  logic              show_contact;
  logic [QCNT_W:0]   reserved;

  logic              in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;

  // Room for the queue contents plus every word in flight plus one more
  assign reserved = {1'b0, q_cnt_r} + (QCNT_W + 1)'(s1_valid_r)
                  + (QCNT_W + 1)'(s2_valid_r) + (QCNT_W + 1)'(s3_valid_r);
  assign in_ch.ready  = reserved < (QCNT_W + 1)'(QDEPTH);
  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palm_major_r <= PALM_THR_RST;
      palm_minor_r <= PALM_THR_RST;
      x_origin_r   <= '0;
      y_top_r      <= '0;
      x_span_r     <= '0;
      y_span_r     <= '0;
      report_en_r  <= 1'b1;
      idle_gap_r   <= IDLE_GAP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_PALM_MAJOR: palm_major_r <= cfg_ch.wdata;
        CFG_PALM_MINOR: palm_minor_r <= cfg_ch.wdata;
        CFG_X_ORIGIN:   x_origin_r   <= cfg_ch.wdata;
        CFG_Y_TOP:      y_top_r      <= cfg_ch.wdata;
        CFG_X_SPAN:     x_span_r     <= cfg_ch.wdata;
        CFG_Y_SPAN:     y_span_r     <= cfg_ch.wdata;
        CFG_REPORT_EN:  report_en_r  <= cfg_ch.wdata[0];
        CFG_IDLE_GAP:   idle_gap_r   <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_ch.data;
    end
  end

  // Stage 1 logic: frame control, length check, gap subtract, contact math
  always_comb begin
    logic [NEED_W-1:0]  need;
    logic [CNT_W-1:0]   adj;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   rep_inc;
    logic               palm;
    logic signed [16:0] nx, ny;

    s1_entry        = '0;
    s1_hdr_open     = 1'b0;
    s1_cap_ok       = 1'b0;
    last_time_nxt   = last_time_r;
    prev_total_nxt  = prev_total_r;
    frame_open_nxt  = frame_open_r;
    expected_nxt    = expected_r;
    finger_idx_nxt  = finger_idx_r;
    reported_nxt    = reported_r;
    frame_click_nxt = frame_click_r;

    // Gap since the last accepted frame, saturation decided here
    s1_diff = s1_item_r.timestamp - last_time_r;
    s1_sat  = (s1_diff[63:DIV_IN_W] != '0) ||
              (s1_diff[DIV_IN_W-1:0] >= DIV_IN_W'(SCAN_LIMIT));

    need = NEED_W'(HEADER_BYTES)
         + NEED_W'(s1_item_r.finger_count) * NEED_W'(FINGER_RECORD_BYTES);
    adj  = (s1_item_r.finger_count > 8'(MAX_CONTACTS)) ? CNT_W'(MAX_CONTACTS)
                                                       : s1_item_r.finger_count[CNT_W-1:0];

    palm = (s1_item_r.touch_major >= palm_major_r) &&
           (s1_item_r.touch_minor >= palm_minor_r);
    nx = {s1_item_r.finger_x[15], s1_item_r.finger_x} - $signed({x_origin_r[15], x_origin_r});
    ny = $signed({y_top_r[15], y_top_r}) - {s1_item_r.finger_y[15], s1_item_r.finger_y};
    idx_inc = finger_idx_r + CNT_W'(1);
    rep_inc = palm ? reported_r : reported_r + CNT_W'(1);

    if (s1_valid_r) begin
      case (s1_item_r.op)
        OP_HEADER: begin
          frame_open_nxt       = 1'b0;
          s1_entry.has_summary = 1'b1;
          s1_entry.scan_src    = SCAN_ZERO;
          s1_entry.sum_status  = STATUS_OK;
          if (!report_en_r) begin
            // disabled: empty summary, timing state kept, any open frame closed
          end else if ({1'b0, s1_item_r.packet_length} < need) begin
            s1_entry.sum_status = STATUS_LEN_ERR;
          end else begin
            last_time_nxt  = s1_item_r.timestamp;
            s1_cap_ok      = (prev_total_r == '0) && (adj != '0);
            prev_total_nxt = adj;
            if (adj == '0) begin
              s1_entry.sum_click = s1_item_r.click;
              s1_entry.scan_src  = SCAN_OWN;
            end else begin
              // the opening header resolves its own scan time for the frame
              s1_entry.scan_src    = SCAN_OWN;
              s1_entry.has_summary = 1'b0;
              s1_hdr_open          = 1'b1;
              frame_open_nxt       = 1'b1;
              expected_nxt         = adj;
              finger_idx_nxt       = '0;
              reported_nxt         = '0;
              frame_click_nxt      = s1_item_r.click;
            end
          end
        end
        OP_FINGER: begin
          if (frame_open_r) begin
            if (!palm) begin
              s1_entry.has_contact = 1'b1;
              s1_entry.contact_id  = finger_idx_r;
              s1_entry.pos_x       = clamp_span(nx, x_span_r);
              s1_entry.pos_y       = clamp_span(ny, y_span_r);
              s1_entry.tip         = !s1_item_r.finger_pressure[15] &&
                                     (s1_item_r.finger_pressure != '0);
            end
            reported_nxt   = rep_inc;
            finger_idx_nxt = idx_inc;
            // last expected record closes the frame
            if (idx_inc >= expected_r) begin
              s1_entry.has_summary = 1'b1;
              s1_entry.sum_count   = rep_inc;
              s1_entry.sum_click   = frame_click_r;
              s1_entry.sum_status  = STATUS_OK;
              s1_entry.scan_src    = SCAN_FRAME;
              frame_open_nxt       = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Frame and timing state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r   <= '0;
      prev_total_r  <= '0;
      frame_open_r  <= 1'b0;
      expected_r    <= '0;
      finger_idx_r  <= '0;
      reported_r    <= '0;
      frame_click_r <= 1'b0;
    end else begin
      last_time_r   <= last_time_nxt;
      prev_total_r  <= prev_total_nxt;
      frame_open_r  <= frame_open_nxt;
      expected_r    <= expected_nxt;
      finger_idx_r  <= finger_idx_nxt;
      reported_r    <= reported_nxt;
      frame_click_r <= frame_click_nxt;
    end
  end

  // Stage 2 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_entry_r    <= s1_entry;
    s2_hdr_open_r <= s1_hdr_open;
    s2_cap_ok_r   <= s1_cap_ok;
    s2_sat_r      <= s1_sat;
    s2_diff_r     <= s1_diff[DIV_IN_W-1:0];
  end

  // Stage 2 logic: divide by 1000 through the reciprocal
  assign s2_prod = PROD_W'(s2_diff_r) * PROD_W'(DIV_RECIP);

  // Stage 3 register
  always_ff @(posedge clk) begin
    s3_entry_r    <= s2_entry_r;
    s3_hdr_open_r <= s2_hdr_open_r;
    s3_cap_ok_r   <= s2_cap_ok_r;
    s3_sat_r      <= s2_sat_r;
    s3_quot_r     <= s2_prod[DIV_SHIFT +: SCAN_W];
  end

  // Stage 3 logic: saturate, first-frame cap, pick the summary scan time
  always_comb begin
    logic [SCAN_W-1:0] scan_calc;
    logic [SCAN_W-1:0] scan_own;

    scan_calc = s3_sat_r ? SCAN_W'(SCAN_MAX) : s3_quot_r;
    scan_own  = (s3_cap_ok_r && (scan_calc > idle_gap_r)) ? SCAN_W'(FIRST_FRAME_CAP)
                                                          : scan_calc;
    s3_q.e = s3_entry_r;
    case (s3_entry_r.scan_src)
      SCAN_ZERO:  s3_q.scan = '0;
      SCAN_OWN:   s3_q.scan = scan_own;
      SCAN_FRAME: s3_q.scan = frame_scan_r;
      default:    s3_q.scan = '0;
    endcase
  end

  // Opened frame keeps its scan time for the closing summary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_scan_r <= '0;
    end else if (s3_valid_r && s3_hdr_open_r) begin
      frame_scan_r <= s3_q.scan;
    end
  end

  // Result queue: one entry per input word that yields a result, one or two output words per entry
  assign push         = s3_valid_r && (s3_entry_r.has_contact || s3_entry_r.has_summary);
  assign head         = q_mem[rd_ptr_r];
  assign show_contact = head.e.has_contact && !phase_r;
  assign pop_word     = out_ch.valid && out_ch.ready;
  assign pop_entry    = pop_word && (!show_contact || !head.e.has_summary);

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= s3_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
      phase_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop_entry) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
        phase_r  <= 1'b0;
      end else if (pop_word) begin
        phase_r  <= 1'b1;
      end
      case ({push, pop_entry})
        2'b10:   q_cnt_r <= q_cnt_r + QCNT_W'(1);
        2'b01:   q_cnt_r <= q_cnt_r - QCNT_W'(1);
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  // Output word from the queue head
  always_comb begin
    out_ch.data = '0;
    if (show_contact) begin
      out_ch.data.kind       = KIND_CONTACT;
      out_ch.data.contact_id = head.e.contact_id;
      out_ch.data.pos_x      = head.e.pos_x;
      out_ch.data.pos_y      = head.e.pos_y;
      out_ch.data.tip_switch = head.e.tip;
      out_ch.data.status     = STATUS_OK;
      out_ch.data.last       = 1'b0;
    end else begin
      out_ch.data.kind           = KIND_SUMMARY;
      out_ch.data.contact_count  = head.e.sum_count;
      out_ch.data.button_clicked = head.e.sum_click;
      out_ch.data.scan_time      = head.scan;
      out_ch.data.status         = head.e.sum_status;
      out_ch.data.last           = 1'b1;
    end
  end

  assign out_ch.valid = (q_cnt_r != '0);

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for touch_frame_to_contact_report_top.
// Drives header and finger words with random stalls on both channels, predicts each
// contact and summary word in-bench. Depends on tfcr_pkg and the three channel interfaces.
`timescale 1ns / 1ps

module testbench;
  import tfcr_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [15:0]        palm_major;
    logic [15:0]        palm_minor;
    logic signed [15:0] x_origin;
    logic signed [15:0] y_top;
    logic [15:0]        x_span;
    logic [15:0]        y_span;
    logic               report_en;
    logic [15:0]        idle_gap;
  } trackpad_settings_t;

  logic clk = 1'b0;
  logic rst_n;

  tfcr_in_if  in_ch ();
  tfcr_out_if out_ch ();
  tfcr_cfg_if cfg_ch ();

  touch_frame_to_contact_report_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Register copy and frame tracking state used for prediction
  trackpad_settings_t cur;
  logic [63:0] prev_stamp;
  logic [2:0]  prev_fingers;
  logic        frame_live;
  logic [2:0]  frame_fingers;
  logic [2:0]  finger_pos;
  logic [2:0]  frame_contacts;
  logic        frame_click_flag;
  logic [15:0] frame_scan;

  out_word_t expected_words[$];
  out_word_t want;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic [63:0] ts_clock = '0;

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [15:0] clamp_coord(int n, logic [15:0] span);
    if (n <= 0) return 16'd0;
    if (n >= int'(span)) return span;
    return 16'(n);
  endfunction

  function automatic out_word_t summary_word(logic [2:0] cnt, logic clicked,
                                             logic [15:0] scan, status_t st);
    out_word_t s;
    s = '0;
    s.kind           = KIND_SUMMARY;
    s.contact_count  = cnt;
    s.button_clicked = clicked;
    s.scan_time      = scan;
    s.status         = st;
    s.last           = 1'b1;
    return s;
  endfunction

  // Expected result words for one accepted input word
  function automatic void predict_word(in_word_t w);
    out_word_t   c;
    logic [63:0] gap;
    logic [15:0] scan;
    int          need;
    int          adj;
    if (w.op == OP_HEADER) begin
      frame_live = 1'b0;
      need = HEADER_BYTES + int'(w.finger_count) * FINGER_RECORD_BYTES;
      if (!cur.report_en) begin
        expected_words.push_back(summary_word(3'd0, 1'b0, 16'd0, STATUS_OK));
        return;
      end
      if (int'(w.packet_length) < HEADER_BYTES || int'(w.packet_length) < need) begin
        expected_words.push_back(summary_word(3'd0, 1'b0, 16'd0, STATUS_LEN_ERR));
        return;
      end
      gap = (w.timestamp - prev_stamp) / 64'(TICKS_PER_UNIT);
      scan = (gap > 64'(SCAN_MAX)) ? 16'(SCAN_MAX) : gap[15:0];
      prev_stamp = w.timestamp;
      adj = (int'(w.finger_count) > MAX_CONTACTS) ? MAX_CONTACTS : int'(w.finger_count);
      // first frame after an empty one: long idle gaps are capped
      if (prev_fingers == 3'd0 && adj > 0 && scan > cur.idle_gap)
        scan = 16'(FIRST_FRAME_CAP);
      prev_fingers = 3'(adj);
      if (adj == 0) begin
        expected_words.push_back(summary_word(3'd0, w.click, scan, STATUS_OK));
        return;
      end
      frame_live       = 1'b1;
      frame_fingers    = 3'(adj);
      finger_pos       = 3'd0;
      frame_contacts   = 3'd0;
      frame_click_flag = w.click;
      frame_scan       = scan;
    end else begin
      if (!frame_live) return;
      // palm: both axes at or above their thresholds
      if (!(w.touch_major >= cur.palm_major && w.touch_minor >= cur.palm_minor)) begin
        c = '0;
        c.kind       = KIND_CONTACT;
        c.contact_id = finger_pos;
        c.pos_x      = clamp_coord(int'($signed(w.finger_x)) - int'(cur.x_origin), cur.x_span);
        c.pos_y      = clamp_coord(int'(cur.y_top) - int'($signed(w.finger_y)), cur.y_span);
        c.tip_switch = ($signed(w.finger_pressure) >= 16'sd1);
        c.status     = STATUS_OK;
        expected_words.push_back(c);
        frame_contacts = frame_contacts + 3'd1;
      end
      finger_pos = finger_pos + 3'd1;
      if (finger_pos >= frame_fingers) begin
        expected_words.push_back(summary_word(frame_contacts, frame_click_flag,
                                              frame_scan, STATUS_OK));
        frame_live = 1'b0;
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h got %0h", $time, name, e, a);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected, got %h", $time, out_ch.data);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("kind", want.kind, out_ch.data.kind);
        check_field("contact_id", want.contact_id, out_ch.data.contact_id);
        check_field("pos_x", want.pos_x, out_ch.data.pos_x);
        check_field("pos_y", want.pos_y, out_ch.data.pos_y);
        check_field("tip_switch", want.tip_switch, out_ch.data.tip_switch);
        check_field("contact_count", want.contact_count, out_ch.data.contact_count);
        check_field("button_clicked", want.button_clicked, out_ch.data.button_clicked);
        check_field("scan_time", want.scan_time, out_ch.data.scan_time);
        check_field("status", want.status, out_ch.data.status);
        check_field("last", want.last, out_ch.data.last);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // One input word; valid stays up unless an idle cycle is taken before the next
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(w);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_PALM_MAJOR: cur.palm_major = value;
      CFG_PALM_MINOR: cur.palm_minor = value;
      CFG_X_ORIGIN:   cur.x_origin   = value;
      CFG_Y_TOP:      cur.y_top      = value;
      CFG_X_SPAN:     cur.x_span     = value;
      CFG_Y_SPAN:     cur.y_span     = value;
      CFG_REPORT_EN:  cur.report_en  = value[0];
      CFG_IDLE_GAP:   cur.idle_gap   = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(trackpad_settings_t s);
    write_reg(CFG_PALM_MAJOR, s.palm_major);
    write_reg(CFG_PALM_MINOR, s.palm_minor);
    write_reg(CFG_X_ORIGIN, s.x_origin);
    write_reg(CFG_Y_TOP, s.y_top);
    write_reg(CFG_X_SPAN, s.x_span);
    write_reg(CFG_Y_SPAN, s.y_span);
    write_reg(CFG_REPORT_EN, {15'd0, s.report_en});
    write_reg(CFG_IDLE_GAP, s.idle_gap);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait for every expected word, then let the pipeline settle
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [15:0] pick_edge16();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic in_word_t random_word(op_t op);
    in_word_t w;
    w.op              = op;
    w.timestamp       = {$urandom, $urandom};
    w.packet_length   = 16'($urandom);
    w.finger_count    = 8'($urandom);
    w.click           = 1'($urandom);
    w.finger_x        = 16'($urandom);
    w.finger_y        = 16'($urandom);
    w.finger_pressure = 16'($urandom);
    w.touch_major     = 16'($urandom);
    w.touch_minor     = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t header_word(logic [63:0] ts, logic [15:0] len,
                                           logic [7:0] cnt, logic clicked);
    in_word_t w;
    w = random_word(OP_HEADER);
    w.timestamp     = ts;
    w.packet_length = len;
    w.finger_count  = cnt;
    w.click         = clicked;
    return w;
  endfunction

  function automatic in_word_t finger_word(logic [15:0] x, logic [15:0] y, logic [15:0] p,
                                           logic [15:0] major, logic [15:0] minor);
    in_word_t w;
    w = random_word(OP_FINGER);
    w.finger_x        = x;
    w.finger_y        = y;
    w.finger_pressure = p;
    w.touch_major     = major;
    w.touch_minor     = minor;
    return w;
  endfunction

  // Axis size spread around the palm threshold
  function automatic logic [15:0] pick_axis(logic [15:0] thr);
    case ($urandom_range(4))
      0: return 16'($urandom);
      1: return 16'(int'(thr) + $urandom_range(0, 2) - 1);
      2: return 16'($urandom_range(0, thr));
      3: return 16'($urandom_range(thr, 16'hFFFF));
      default: return pick_edge16();
    endcase
  endfunction

  function automatic logic [15:0] pick_pressure();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'hFFFF;
      2: return 16'd0;
      3: return 16'd1;
      4: return pick_edge16();
      default: return 16'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic in_word_t random_finger();
    logic [15:0] x;
    logic [15:0] y;
    case ($urandom_range(3))
      0: begin x = 16'($urandom); y = 16'($urandom); end
      1: begin x = pick_edge16(); y = pick_edge16(); end
      default: begin
        // mostly inside the active area, a little past each edge
        x = 16'(int'(cur.x_origin) + $urandom_range(0, int'(cur.x_span) + 200) - 100);
        y = 16'(int'(cur.y_top) - $urandom_range(0, int'(cur.y_span) + 200) + 100);
      end
    endcase
    return finger_word(x, y, pick_pressure(), pick_axis(cur.palm_major),
                       pick_axis(cur.palm_minor));
  endfunction

  function automatic logic [63:0] next_timestamp();
    case ($urandom_range(9))
      0: ts_clock = {$urandom, $urandom};
      1, 2: ts_clock = ts_clock + $urandom_range(0, 2000);
      3: ts_clock = ts_clock + $urandom_range(60_000_000, 80_000_000);
      default: ts_clock = ts_clock + $urandom_range(0, 8_000_000);
    endcase
    return ts_clock;
  endfunction

  function automatic int pick_count();
    case ($urandom_range(9))
      0, 1: return 0;
      2: return $urandom_range(MAX_CONTACTS + 1, 7);
      3: return $urandom_range(0, 255);
      default: return $urandom_range(1, MAX_CONTACTS);
    endcase
  endfunction

  function automatic trackpad_settings_t random_settings(bit extremes);
    trackpad_settings_t s;
    if (extremes) begin
      s.palm_major = pick_edge16();
      s.palm_minor = pick_edge16();
      s.x_origin   = pick_edge16();
      s.y_top      = pick_edge16();
      s.x_span     = pick_edge16();
      s.y_span     = pick_edge16();
      s.report_en  = 1'b1;
      s.idle_gap   = pick_edge16();
    end else begin
      s.palm_major = 16'($urandom_range(500, 6000));
      s.palm_minor = 16'($urandom_range(500, 6000));
      s.x_origin   = 16'($urandom);
      s.y_top      = 16'($urandom);
      s.x_span     = 16'($urandom_range(100, 4000));
      s.y_span     = 16'($urandom_range(100, 4000));
      s.report_en  = ($urandom_range(9) != 0);
      s.idle_gap   = 16'($urandom_range(0, 12000));
    end
    return s;
  endfunction

  // ---------------------------------------------------------------- tests

  // Reset values: zero spans pin every position to 0
  task automatic test_reset_defaults();
    ts_clock = 64'd20000;
    send_word(header_word(ts_clock, 16'd76, 8'd1, 1'b1));
    send_word(finger_word(16'd100, 16'hFF9C, 16'd1, 16'd0, 16'd0));
  endtask

  task automatic test_length_checks();
    ts_clock = ts_clock + 64'd3000;
    send_word(header_word(ts_clock, 16'd45, 8'd0, 1'b1));          // below header size
    send_word(header_word(ts_clock, 16'd105, 8'd2, 1'b1));         // one byte short of two fingers
  endtask

  task automatic test_frame_shapes();
    ts_clock = ts_clock + 64'd4000;
    send_word(header_word(ts_clock, 16'd46, 8'd0, 1'b1));          // empty frame
    send_word(finger_word(16'd10, 16'd10, 16'd5, 16'd0, 16'd0));  // no frame open
    // long idle after an empty frame, excess finger count
    ts_clock = ts_clock + 64'd10_000_000;
    send_word(header_word(ts_clock, 16'hFFFF, 8'hFF, 1'b1));
    send_word(finger_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0));
    send_word(finger_word(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0));
    send_word(finger_word(16'd500, 16'd100, 16'd0, 16'd3499, 16'hFFFF));
    send_word(finger_word(16'd0, 16'd0, 16'd1, 16'd3500, 16'd3000));     // palm at thresholds
    send_word(finger_word(16'd0, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF));     // last one is palm
    send_word(finger_word(16'd1, 16'd1, 16'd1, 16'd0, 16'd0));           // beyond the cap
    // new header while a frame is still open; timestamp steps back
    ts_clock = ts_clock + 64'd1000;
    send_word(header_word(ts_clock, 16'd136, 8'd3, 1'b0));
    send_word(finger_word(16'd1999, 16'd2000, 16'd2, 16'd0, 16'hFFFF));
    send_word(header_word(64'd5, 16'd76, 8'd1, 1'b0));
    send_word(finger_word(16'hFC18, 16'hF63C, 16'd1, 16'hFFFF, 16'd2999));
  endtask

  task automatic test_disabled();
    send_word(header_word(ts_clock + 64'd5000, 16'd76, 8'd1, 1'b1));
    send_word(header_word(ts_clock, 16'd0, 8'd9, 1'b1));
    send_word(finger_word(16'd1, 16'd1, 16'd1, 16'd0, 16'd0));
  endtask

  // Mostly well-formed frames with random content, plus truncation and noise
  task automatic run_random_traffic(int n_items);
    int          sent;
    int          cnt;
    int          need;
    int          n_fing;
    logic [15:0] len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        15, 16: begin
          // too short for the claimed count
          cnt  = $urandom_range(0, 255);
          need = HEADER_BYTES + cnt * FINGER_RECORD_BYTES;
          send_word(header_word(next_timestamp(), 16'($urandom_range(0, need - 1)),
                                8'(cnt), 1'($urandom)));
          sent++;
        end
        17, 18: begin
          send_word(random_finger());
          sent++;
        end
        19: begin
          send_word(random_word(op_t'($urandom_range(1))));
          sent++;
        end
        default: begin
          cnt  = pick_count();
          need = HEADER_BYTES + cnt * FINGER_RECORD_BYTES;
          case ($urandom_range(9))
            0: len = 16'($urandom);
            1: len = 16'(need);
            default: len = 16'(need + $urandom_range(0, 40));
          endcase
          send_word(header_word(next_timestamp(), len, 8'(cnt), 1'($urandom)));
          sent++;
          n_fing = (cnt > MAX_CONTACTS) ? $urandom_range(MAX_CONTACTS, MAX_CONTACTS + 2) : cnt;
          if (n_fing > 0 && $urandom_range(9) == 0) n_fing = $urandom_range(0, n_fing - 1);
          repeat (n_fing) begin
            send_word(random_finger());
            sent++;
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    trackpad_settings_t s;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_PALM_MAJOR;
    cfg_ch.wdata  <= '0;
    cur.palm_major = PALM_THR_RST;
    cur.palm_minor = PALM_THR_RST;
    cur.x_origin   = '0;
    cur.y_top      = '0;
    cur.x_span     = '0;
    cur.y_span     = '0;
    cur.report_en  = 1'b1;
    cur.idle_gap   = IDLE_GAP_RST;
    prev_stamp       = '0;
    prev_fingers     = '0;
    frame_live       = 1'b0;
    frame_fingers    = '0;
    finger_pos       = '0;
    frame_contacts   = '0;
    frame_click_flag = 1'b0;
    frame_scan       = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 67;
    test_reset_defaults();
    finish_phase();

    s.palm_major = 16'd3500;
    s.palm_minor = 16'd3000;
    s.x_origin   = -16'sd1000;
    s.y_top      = 16'sd2000;
    s.x_span     = 16'd3000;
    s.y_span     = 16'd2500;
    s.report_en  = 1'b1;
    s.idle_gap   = 16'd5000;
    apply_settings(s);
    test_length_checks();
    test_frame_shapes();
    finish_phase();

    s.report_en = 1'b0;
    apply_settings(s);
    test_disabled();
    finish_phase();

    // three stall profiles, each over one extreme and two random settings
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 67 : 0;
      recv_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 11 : 0;
      for (int k = 0; k < 3; k++) begin
        apply_settings(random_settings(k == 0));
        run_random_traffic(56);
        finish_phase();
      end
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
